// ===== rtl/core/output_branch_selector_unit_assert.svh =====
// Assertion macros used by the checker of the branch selector.
`ifndef OUTPUT_BRANCH_SELECTOR_UNIT_ASSERT_SVH
`define OUTPUT_BRANCH_SELECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define OBSU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high
`define OBSU_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/obs_pkg.sv =====
package obs_pkg;

  localparam int DEF_MAX_BRANCHES = 8;
  localparam int DEF_WEIGHT_BITS  = 8;

  localparam int TAG_W        = 32;
  localparam int BRANCH_W     = 3;
  localparam int COUNT_W      = 4;
  localparam int MODE_W       = 3;
  localparam int TABLE_W      = 64;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 40;
  localparam int OUT_FIELDS_W = 1 + BRANCH_W + TAG_W;
  localparam int QUEUE_DEPTH  = 2;

  // Weighted mode counter period and its width
  localparam int PRECISION = 1000;
  localparam int PREC_W    = 10;

  // Reciprocal of the period: x / 1000 == (x * PREC_RECIP) >> PREC_SHIFT for any 32-bit x
  localparam logic [TAG_W-1:0] PREC_RECIP = 32'h1062_4dd3;
  localparam int               PREC_SHIFT = 38;

  // fmix32 multipliers
  localparam logic [TAG_W-1:0] MIX_MUL_A = 32'h85eb_ca6b;
  localparam logic [TAG_W-1:0] MIX_MUL_B = 32'hc2b2_ae35;

  // Route modes
  localparam logic [MODE_W-1:0] MODE_PLAIN  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CMP    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RR     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HASH   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_WEIGHT = 3'd4;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ROUTE_MODE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COMPARAND    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BRANCH_COUNT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_TABLE = 3'd3;

  // Comparator branch codes
  localparam logic [1:0] CMP_LESS    = 2'd0;
  localparam logic [1:0] CMP_EQUAL   = 2'd1;
  localparam logic [1:0] CMP_GREATER = 2'd2;

  // What the back end has to do with an item
  typedef enum logic [2:0] {
    K_BCAST,
    K_CMP,
    K_RR,
    K_HASH,
    K_WEIGHT
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [1:0] cmp_branch;
  } item_t;

  typedef struct packed {
    logic [MODE_W-1:0]        route_mode;
    logic signed [TAG_W-1:0]  comparand;
    logic [COUNT_W-1:0]       branch_count;
    logic [TABLE_W-1:0]       weight_table;
  } cfg_t;

  // Branch count clamped to the number of branches built
  function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] bc,
                                                   input int unsigned max_b);
    logic [COUNT_W-1:0] n;
    n = (32'(bc) > max_b) ? COUNT_W'(max_b) : bc;
    return n;
  endfunction

endpackage

// ===== rtl/core/obs_front.sv =====
module obs_front #(
  parameter int MAX_BRANCHES = obs_pkg::DEF_MAX_BRANCHES
) (
  input  obs_pkg::cfg_t                     cfg,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [obs_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                              push_valid,
  input  logic                              push_ready,
  output obs_pkg::item_t                    push_item
);
  import obs_pkg::*;

  logic [COUNT_W-1:0]          n_eff;
  logic signed [IN_TDATA_W-1:0] value_q16;
  logic [1:0]                  cmp_branch;
  kind_t                       kind;

  assign n_eff     = eff_count(cfg.branch_count, MAX_BRANCHES);
  assign value_q16 = $signed(s_tdata);

  // Signed compare against the threshold
  always_comb begin
    if (value_q16 < cfg.comparand) begin
      cmp_branch = CMP_LESS;
    end else if (value_q16 > cfg.comparand) begin
      cmp_branch = CMP_GREATER;
    end else begin
      cmp_branch = CMP_EQUAL;
    end
  end

  // Classify; counter modes with no branches fall back to broadcast
  always_comb begin
    unique case (cfg.route_mode)
      MODE_PLAIN:  kind = K_BCAST;
      MODE_CMP:    kind = K_CMP;
      MODE_RR:     kind = (n_eff == '0) ? K_BCAST : K_RR;
      MODE_HASH:   kind = (n_eff == '0) ? K_BCAST : K_HASH;
      MODE_WEIGHT: kind = (n_eff == '0) ? K_BCAST : K_WEIGHT;
      default:     kind = K_BCAST;
    endcase
  end

  assign push_valid           = s_tvalid;
  assign s_tready             = push_ready;
  assign push_item.kind       = kind;
  assign push_item.cmp_branch = cmp_branch;

endmodule

// ===== rtl/core/obs_queue.sv =====
module obs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  obs_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output obs_pkg::item_t pop_item
);
  import obs_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/core/obs_back.sv =====
module obs_back #(
  parameter int MAX_BRANCHES = obs_pkg::DEF_MAX_BRANCHES,
  parameter int WEIGHT_BITS  = obs_pkg::DEF_WEIGHT_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  obs_pkg::cfg_t                     cfg,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  obs_pkg::item_t                    pop_item,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [obs_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import obs_pkg::*;

  localparam int IDX_W  = (MAX_BRANCHES > 1) ? $clog2(MAX_BRANCHES) : 1;
  localparam int LANES  = 2 ** IDX_W;
  localparam int TOT_W  = WEIGHT_BITS + IDX_W;
  localparam int PROD_W = PREC_W + TOT_W;
  localparam int DSOR_W = PREC_W;
  localparam int DCNT_W = $clog2(TAG_W);
  localparam int PAD_W  = OUT_TDATA_W - OUT_FIELDS_W;
  localparam int QUO_W  = 2 * TAG_W - PREC_SHIFT;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MIX   = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_TOTAL = 8'b0000_1000,
    S_PROD  = 8'b0001_0000,
    S_SCAN  = 8'b0010_0000,
    S_DONE  = 8'b0100_0000,
    S_RECIP = 8'b1000_0000
  } state_t;

  state_t              state;
  kind_t               cur_kind;
  logic [TAG_W-1:0]    route_counter;
  logic [TAG_W-1:0]    tag;
  logic [TAG_W-1:0]    mix;
  logic [TAG_W-1:0]    dvd;
  logic [DSOR_W-1:0]   rem;
  logic [DSOR_W-1:0]   dsor;
  logic [DCNT_W-1:0]   div_cnt;
  logic [IDX_W-1:0]    k;
  logic [TOT_W-1:0]    total;
  logic [TOT_W-1:0]    acc;
  logic [PROD_W-1:0]   prod;
  logic [QUO_W-1:0]    quo;
  logic                res_bcast;
  logic [BRANCH_W-1:0] res_branch;

  logic [COUNT_W-1:0]              n_eff;
  logic [IDX_W-1:0]                n_m1;
  logic [TABLE_W+WEIGHT_BITS-1:0]  wext;
  logic [WEIGHT_BITS-1:0]          wlane [LANES];
  logic [WEIGHT_BITS-1:0]          w_cur;
  logic [DSOR_W:0]                 trial;
  logic [DSOR_W-1:0]               rem_step;
  logic [DSOR_W-1:0]               rem_plus;
  logic [TAG_W-1:0]                ctr_wrap;
  logic [2*TAG_W-1:0]              recip_prod;
  logic [TAG_W-1:0]                quo_scaled;
  logic [PREC_W-1:0]               pos;
  logic [PREC_W-1:0]               pos_plus;
  logic [TAG_W-1:0]                pos_wrap;
  logic [TAG_W-1:0]                ctr_x16;
  logic [TAG_W-1:0]                mix_x13;
  logic [TAG_W-1:0]                mix_b;
  logic [TOT_W-1:0]                total_sum;
  logic [TOT_W-1:0]                acc_sum;
  logic [PROD_W-1:0]               scaled;
  logic                            slot_free;

  assign n_eff = eff_count(cfg.branch_count, MAX_BRANCHES);
  assign n_m1  = IDX_W'(n_eff - COUNT_W'(1));

  // Weight lanes; weights past the end of the table read as zero
  assign wext = {{WEIGHT_BITS{1'b0}}, cfg.weight_table};
  for (genvar j = 0; j < LANES; j++) begin : g_lane
    if (j < MAX_BRANCHES && j * WEIGHT_BITS < TABLE_W) begin : g_on
      assign wlane[j] = wext[j*WEIGHT_BITS +: WEIGHT_BITS];
    end else begin : g_off
      assign wlane[j] = '0;
    end
  end
  assign w_cur = wlane[k];

  // One restoring remainder step per cycle
  assign trial    = {rem, dvd[TAG_W-1]};
  assign rem_step = (trial >= {1'b0, dsor}) ? DSOR_W'(trial - {1'b0, dsor})
                                            : DSOR_W'(trial);
  assign rem_plus = rem_step + DSOR_W'(1);
  assign ctr_wrap = (rem_plus == dsor) ? '0 : TAG_W'(rem_plus);

  // Position in the weighted period by reciprocal multiplication
  assign recip_prod = {{TAG_W{1'b0}}, route_counter} * {{TAG_W{1'b0}}, PREC_RECIP};
  assign quo_scaled = TAG_W'(quo) * TAG_W'(PRECISION);
  assign pos        = PREC_W'(dvd - quo_scaled);
  assign pos_plus   = pos + PREC_W'(1);
  assign pos_wrap   = (pos_plus == PREC_W'(PRECISION)) ? '0 : TAG_W'(pos_plus);

  // Hash mixing terms
  assign ctr_x16 = route_counter ^ (route_counter >> 16);
  assign mix_x13 = mix ^ (mix >> 13);
  assign mix_b   = TAG_W'(mix_x13 * MIX_MUL_B);

  // Weighted scan terms
  assign total_sum = total + TOT_W'(w_cur);
  assign acc_sum   = acc + TOT_W'(w_cur);
  assign scaled    = PROD_W'(PRECISION) * PROD_W'(acc_sum);

  assign slot_free = !m_tvalid || m_tready;
  assign pop_ready = (state == S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      route_counter <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (state == S_DONE && slot_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop_valid) begin
            cur_kind <= pop_item.kind;
            rem      <= '0;
            div_cnt  <= '0;
            dvd      <= route_counter;
            case (pop_item.kind)
              K_CMP: begin
                res_bcast  <= 1'b0;
                res_branch <= BRANCH_W'(pop_item.cmp_branch);
                tag        <= '0;
                state      <= S_DONE;
              end
              K_RR: begin
                dsor  <= DSOR_W'(n_eff);
                state <= S_DIV;
              end
              K_WEIGHT: begin
                quo   <= recip_prod[2*TAG_W-1:PREC_SHIFT];
                state <= S_RECIP;
              end
              K_HASH: begin
                tag           <= route_counter;
                route_counter <= route_counter + TAG_W'(1);
                mix           <= TAG_W'(ctr_x16 * MIX_MUL_A);
                state         <= S_MIX;
              end
              default: begin
                res_bcast  <= 1'b1;
                res_branch <= '0;
                tag        <= '0;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_RECIP: begin
          // position in the period becomes the tag; advance the counter
          tag           <= TAG_W'(pos);
          route_counter <= pos_wrap;
          k             <= '0;
          total         <= '0;
          state         <= S_TOTAL;
        end
        S_MIX: begin
          dvd   <= mix_b ^ (mix_b >> 16);
          dsor  <= DSOR_W'(n_eff);
          state <= S_DIV;
        end
        S_DIV: begin
          dvd     <= dvd << 1;
          rem     <= rem_step;
          div_cnt <= div_cnt + DCNT_W'(1);
          if (div_cnt == DCNT_W'(TAG_W - 1)) begin
            case (cur_kind)
              K_RR: begin
                res_bcast     <= 1'b0;
                res_branch    <= BRANCH_W'(rem_step);
                tag           <= TAG_W'(rem_step);
                route_counter <= ctr_wrap;
                state         <= S_DONE;
              end
              default: begin
                // hashed: remainder of the mixed counter picks the branch
                res_bcast  <= 1'b0;
                res_branch <= BRANCH_W'(rem_step);
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_TOTAL: begin
          total <= total_sum;
          if (k == n_m1) begin
            k   <= '0;
            acc <= '0;
            if (total_sum == '0) begin
              res_bcast  <= 1'b1;
              res_branch <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_PROD;
            end
          end else begin
            k <= k + IDX_W'(1);
          end
        end
        S_PROD: begin
          prod  <= PROD_W'(tag[PREC_W-1:0]) * PROD_W'(total);
          state <= S_SCAN;
        end
        S_SCAN: begin
          acc <= acc_sum;
          if (prod < scaled || k == n_m1) begin
            res_bcast  <= 1'b0;
            res_branch <= BRANCH_W'(k);
            state      <= S_DONE;
          end else begin
            k <= k + IDX_W'(1);
          end
        end
        S_DONE: begin
          if (slot_free) begin
            m_tdata <= {{PAD_W{1'b0}}, tag, res_branch, res_bcast};
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/output_branch_selector_unit.sv =====
// Output branch selector: one routing decision per produced value.
// Input stream s_*: s_tdata holds value_q16 (signed Q16.16).
// Output stream m_*: one result transaction per input transaction, in order.
// Config channel cfg_*: index 0 route_mode, 1 comparand, 2 branch_count,
// 3 weight_table; other indexes are ignored. cfg_ready is always high.
// Write configuration only while no transaction is in flight.
// Round robin and hashed modes share a 32-step remainder unit; the
// weighted mode sums and then scans the weights one branch per cycle,
// and broadcasts when all weights are zero. The sequencer takes the
// next item from the queue only after the last result is registered.
// A two-entry queue between the classifier and the sequencer keeps the
// input side open while a result waits; one result register feeds m_*.
// Reset clears the configuration registers and the route counter to zero.
// When m_tready is low the result holds on m_tdata and the sequencer
// waits; the queue then fills and s_tready drops.
module output_branch_selector_unit #(
  parameter int MAX_BRANCHES = obs_pkg::DEF_MAX_BRANCHES,
  parameter int WEIGHT_BITS  = obs_pkg::DEF_WEIGHT_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [obs_pkg::IN_TDATA_W-1:0]     s_tdata,   // [31:0] value_q16
  // Output stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [obs_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [0] broadcast, [3:1] branch,
                                                        // [35:4] order_tag, [39:36] zero
  // Configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [obs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [obs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import obs_pkg::*;

  cfg_t  cfg;
  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  assign cfg_ready = 1'b1;

  // Decode register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROUTE_MODE:   cfg.route_mode   <= cfg_data[MODE_W-1:0];
        REG_COMPARAND:    cfg.comparand    <= $signed(cfg_data[TAG_W-1:0]);
        REG_BRANCH_COUNT: cfg.branch_count <= cfg_data[COUNT_W-1:0];
        REG_WEIGHT_TABLE: cfg.weight_table <= cfg_data[TABLE_W-1:0];
        default: ;
      endcase
    end
  end

  obs_front #(
    .MAX_BRANCHES (MAX_BRANCHES)
  ) u_front (
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  obs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  obs_back #(
    .MAX_BRANCHES (MAX_BRANCHES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ===== rtl/core/obs_checker.sv =====
`include "output_branch_selector_unit_assert.svh"

module obs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [obs_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import obs_pkg::*;

  // Padding above the result fields stays zero
  `OBSU_ASSERT_IMP(a_pad_zero, clk, rst, m_tvalid, m_tdata[OUT_TDATA_W-1:OUT_FIELDS_W] == '0, "result padding not zero")

  // A broadcast result carries branch zero
  `OBSU_ASSERT_IMP(a_bcast_branch, clk, rst, m_tvalid && m_tdata[0], m_tdata[BRANCH_W:1] == '0, "broadcast with nonzero branch")

  // A stalled result stays offered
  `OBSU_ASSERT_NXT(a_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

  // A stalled result keeps its value
  `OBSU_ASSERT_NXT(a_hold_data, clk, rst, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")

endmodule

bind output_branch_selector_unit obs_checker u_obs_checker (.*);
